// ----- sv/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the tone step sequencer
// Step layout, click constants, divider sizes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int ADDR_W   = 8;
    localparam int FREQ_W   = 25;
    localparam int LED_W    = 2;
    localparam int DUR_W    = 16;
    localparam int STEP_W   = FREQ_W + 1 + LED_W + DUR_W;
    localparam int CLOCK_W  = 28;
    localparam int PERIOD_W = 16;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int DIV_W     = CLOCK_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int HZ_W      = 15;

    // hz = (mhz * RECIP_1000) >> RECIP_SHIFT, exact for mhz below 2**24
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 34;
    localparam int PROD_W      = (FREQ_W - 1) + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 25'd17179870;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET    = 28'd1000000;
    localparam logic [FREQ_W-1:0]  CLICK_HIGH_MHZ = 25'd5000000;
    localparam logic [FREQ_W-1:0]  CLICK_LOW_MHZ  = 25'd1000000;
    localparam logic [FREQ_W-1:0]  FREQ_KEEP      = {FREQ_W{1'b1}};
    localparam logic [DUR_W-1:0]   CLICK_DUR      = 16'd4;
    localparam logic [LED_W-1:0]   LED_KEEP       = 2'b11;
    localparam logic [LED_W-1:0]   LED_ON         = 2'b01;
    localparam logic [LED_W-1:0]   LED_OFF        = 2'b00;

    localparam logic [1:0] REG_CLOCK = 2'd0;
    localparam logic [1:0] REG_SPK   = 2'd1;
    localparam logic [1:0] REG_LED   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_PLAY  = 2'd2,
        OP_CLICK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_FETCH,
        S_LOAD,
        S_HZ,
        S_DIV,
        S_APPLY,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              vol;
        logic [LED_W-1:0]  led;
        logic [DUR_W-1:0]  dur;
    } step_t;

    typedef struct packed {
        logic high;
        logic led;
        logic spk;
    } click_snap_t;

    typedef struct packed {
        logic [CLOCK_W-1:0] clock_hz;
        logic               spk_en;
        logic               led_en;
    } cfg_t;

    typedef struct packed {
        logic wr_table;
        logic set_audio;
        logic set_click;
        logic clr_stepped;
        logic tick;
        logic load_step;
        logic div_init;
        logic div_step;
        logic apply;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic tick_due;
        logic seq_go;
        logic div_last;
        logic slot_free;
    } sts_t;

endpackage

// ----- sv/tss_ram.sv -----
// ----------------------------------------------------------------------------
// tss_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
    parameter int WIDTH = tss_pkg::STEP_W,
    parameter int DEPTH = tss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tss_cfg.sv -----
// ----------------------------------------------------------------------------
// tss_cfg: configuration registers
// APB-style register file for the timer clock and the click enables.
// ----------------------------------------------------------------------------
module tss_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tss_pkg::PADDR_W-1:0] paddr,
    input  logic [tss_pkg::PDATA_W-1:0] pwdata,
    output logic [tss_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output tss_pkg::cfg_t               cfg
);

    import tss_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CLOCK: cfg_next.clock_hz = pwdata[CLOCK_W-1:0];
                REG_SPK:   cfg_next.spk_en   = pwdata[0];
                REG_LED:   cfg_next.led_en   = pwdata[0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CLOCK: prdata = PDATA_W'(cfg_reg.clock_hz);
            REG_SPK:   prdata = PDATA_W'(cfg_reg.spk_en);
            REG_LED:   prdata = PDATA_W'(cfg_reg.led_en);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_hz <= CLOCK_RESET;
            cfg_reg.spk_en   <= 1'b0;
            cfg_reg.led_en   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/tss_dp.sv -----
// ----------------------------------------------------------------------------
// tss_dp: sequencer datapath
// Step table, tick counter, sequence state, reciprocal scaling of mHz to Hz,
// restoring period divider, output drive registers and the result register.
// ----------------------------------------------------------------------------
module tss_dp #(
    parameter int TABLE_DEPTH = tss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tss_pkg::cfg_t                      cfg,
    input  tss_pkg::cmd_t                      cmd,
    output tss_pkg::sts_t                      sts,
    input  logic [tss_pkg::ADDR_W-1:0]         addr,
    input  logic signed [tss_pkg::FREQ_W-1:0]  freq_mhz,
    input  logic                               volume,
    input  logic signed [tss_pkg::LED_W-1:0]   led_set,
    input  logic [tss_pkg::DUR_W-1:0]          duration,
    input  logic                               click_high,
    input  logic                               rsp_ready,
    output logic                               rsp_valid,
    output logic                               pwm_running,
    output logic                               mode_a,
    output logic                               mode_b,
    output logic [tss_pkg::PERIOD_W-1:0]       pwm_period,
    output logic                               led_on,
    output logic                               stepped
);

    import tss_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);

    function automatic logic [IDX_W-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
        logic [DEPTH_W:0] rem;
        rem = '0;
        for (int i = ADDR_W - 1; i >= 0; i--)
        begin
            rem = {rem[DEPTH_W-1:0], a[i]};
            if (rem >= (DEPTH_W + 1)'(TABLE_DEPTH))
            begin
                rem = rem - (DEPTH_W + 1)'(TABLE_DEPTH);
            end
        end
        return rem[IDX_W-1:0];
    endfunction

    function automatic step_t click_build(input logic idx, input click_snap_t snap);
        step_t s;
        logic  blink;
        blink = snap.led && snap.high;
        if (!idx)
        begin
            s.freq = snap.spk ? (snap.high ? CLICK_HIGH_MHZ : CLICK_LOW_MHZ) : FREQ_KEEP;
            s.vol  = 1'b1;
            s.led  = blink ? LED_ON : LED_KEEP;
            s.dur  = CLICK_DUR;
        end
        else
        begin
            s.freq = snap.spk ? '0 : FREQ_KEEP;
            s.vol  = 1'b0;
            s.led  = blink ? LED_OFF : LED_KEEP;
            s.dur  = '0;
        end
        return s;
    endfunction

    // sequence and control state
    logic [DUR_W-1:0]    tick_count_reg,    tick_count_next;
    logic [DUR_W-1:0]    ticks_to_next_reg, ticks_to_next_next;
    logic [IDX_W-1:0]    read_index_reg,    read_index_next;
    logic [IDX_W-1:0]    audio_start_reg,   audio_start_next;
    logic                active_reg,        active_next;
    logic                playing_audio_reg, playing_audio_next;
    logic                playing_click_reg, playing_click_next;
    logic                audio_pending_reg, audio_pending_next;
    logic                click_pending_reg, click_pending_next;
    click_snap_t         snap_reg,          snap_next;
    logic                click_step_reg,    click_step_next;
    logic                run_reg,           run_next;
    logic                mode_a_reg,        mode_a_next;
    logic                mode_b_reg,        mode_b_next;
    logic [PERIOD_W-1:0] period_reg,        period_next;
    logic                led_reg,           led_next;
    logic                stepped_reg,       stepped_next;
    logic                rsp_valid_reg,     rsp_valid_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,      div_cnt_next;

    // payload
    step_t               step_reg,          step_next;
    logic [HZ_W-1:0]     hz_reg,            hz_next;
    logic [DIV_W-1:0]    quo_reg,           quo_next;
    logic [HZ_W-1:0]     rem_reg,           rem_next;
    logic                rsp_run_reg,       rsp_run_next;
    logic                rsp_a_reg,         rsp_a_next;
    logic                rsp_b_reg,         rsp_b_next;
    logic [PERIOD_W-1:0] rsp_period_reg,    rsp_period_next;
    logic                rsp_led_reg,       rsp_led_next;
    logic                rsp_stepped_reg,   rsp_stepped_next;

    logic [IDX_W-1:0]    addr_idx;
    logic [DUR_W-1:0]    tick_inc;
    logic                tick_due;
    step_t               wr_step;
    step_t               rd_step;
    logic [STEP_W-1:0]   ram_rdata;
    logic [PROD_W-1:0]   prod;
    logic [HZ_W:0]       div_sh;
    logic [HZ_W+1:0]     div_diff;
    logic                tone;
    logic                tone_off;
    logic [PERIOD_W-1:0] period_sat;

    assign addr_idx = wrap_addr(addr);
    assign tick_inc = tick_count_reg + DUR_W'(1);
    assign tick_due = (tick_inc >= ticks_to_next_reg);

    assign wr_step.freq = freq_mhz;
    assign wr_step.vol  = volume;
    assign wr_step.led  = led_set;
    assign wr_step.dur  = duration;

    tss_ram #(
        .WIDTH (STEP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_table),
        .waddr (addr_idx),
        .wdata (wr_step),
        .raddr (read_index_reg),
        .rdata (ram_rdata)
    );

    assign rd_step = step_t'(ram_rdata);

    assign prod     = PROD_W'(step_reg.freq[FREQ_W-2:0]) * PROD_W'(RECIP_1000);
    assign div_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign div_diff = {1'b0, div_sh} - {2'b00, hz_reg};

    assign tone       = !step_reg.freq[FREQ_W-1] && (step_reg.freq != '0);
    assign tone_off   = (step_reg.freq == '0);
    assign period_sat = (|quo_reg[DIV_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}} :
                        quo_reg[PERIOD_W-1:0];

    assign sts.tick_due  = tick_due;
    assign sts.seq_go    = active_reg || audio_pending_reg || click_pending_reg;
    assign sts.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_W - 1));
    assign sts.slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        tick_count_next    = tick_count_reg;
        ticks_to_next_next = ticks_to_next_reg;
        read_index_next    = read_index_reg;
        audio_start_next   = audio_start_reg;
        active_next        = active_reg;
        playing_audio_next = playing_audio_reg;
        playing_click_next = playing_click_reg;
        audio_pending_next = audio_pending_reg;
        click_pending_next = click_pending_reg;
        snap_next          = snap_reg;
        click_step_next    = click_step_reg;
        run_next           = run_reg;
        mode_a_next        = mode_a_reg;
        mode_b_next        = mode_b_reg;
        period_next        = period_reg;
        led_next           = led_reg;
        stepped_next       = stepped_reg;
        rsp_valid_next     = rsp_valid_reg;
        div_cnt_next       = div_cnt_reg;
        step_next          = step_reg;
        hz_next            = hz_reg;
        quo_next           = quo_reg;
        rem_next           = rem_reg;
        rsp_run_next       = rsp_run_reg;
        rsp_a_next         = rsp_a_reg;
        rsp_b_next         = rsp_b_reg;
        rsp_period_next    = rsp_period_reg;
        rsp_led_next       = rsp_led_reg;
        rsp_stepped_next   = rsp_stepped_reg;

        if (cmd.clr_stepped)
        begin
            stepped_next = 1'b0;
        end

        if (cmd.set_audio)
        begin
            audio_pending_next = 1'b1;
            audio_start_next   = addr_idx;
        end

        if (cmd.set_click)
        begin
            if (cfg.spk_en || cfg.led_en)
            begin
                click_pending_next = 1'b1;
                snap_next.spk      = cfg.spk_en;
                snap_next.led      = cfg.led_en;
                snap_next.high     = click_high;
            end
            else
            begin
                click_pending_next = 1'b0;
            end
        end

        if (cmd.tick)
        begin
            if (!tick_due)
            begin
                tick_count_next = tick_inc;
            end
            else
            begin
                tick_count_next = '0;
                if (!active_reg)
                begin
                    if (audio_pending_reg)
                    begin
                        active_next        = 1'b1;
                        read_index_next    = audio_start_reg;
                        playing_audio_next = 1'b1;
                    end
                    else if (click_pending_reg)
                    begin
                        active_next        = 1'b1;
                        click_step_next    = 1'b0;
                        playing_click_next = 1'b1;
                    end
                end
            end
        end

        if (cmd.load_step)
        begin
            if (playing_audio_reg)
            begin
                step_next       = rd_step;
                read_index_next = (read_index_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 :
                                  read_index_reg + IDX_W'(1);
            end
            else
            begin
                step_next       = click_build(click_step_reg, snap_reg);
                click_step_next = ~click_step_reg;
            end
        end

        if (cmd.div_init)
        begin
            hz_next      = prod[RECIP_SHIFT +: HZ_W];
            quo_next     = cfg.clock_hz;
            rem_next     = '0;
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            if (!div_diff[HZ_W+1])
            begin
                rem_next = div_diff[HZ_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = div_sh[HZ_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.apply)
        begin
            stepped_next = 1'b1;
            if (tone)
            begin
                mode_a_next = 1'b0;
                mode_b_next = !step_reg.vol;
                period_next = period_sat;
                run_next    = 1'b1;
            end
            else if (tone_off)
            begin
                run_next    = 1'b0;
                mode_a_next = 1'b1;
                mode_b_next = 1'b1;
            end
            if (!step_reg.led[LED_W-1])
            begin
                led_next = step_reg.led[0];
            end
            if (step_reg.dur != '0)
            begin
                ticks_to_next_next = step_reg.dur;
            end
            else
            begin
                active_next = 1'b0;
                if (playing_click_reg)
                begin
                    click_pending_next = 1'b0;
                    playing_click_next = 1'b0;
                end
                else if (playing_audio_reg)
                begin
                    audio_pending_next = 1'b0;
                    playing_audio_next = 1'b0;
                end
                ticks_to_next_next = DUR_W'(1);
            end
        end

        if (cmd.load_out)
        begin
            rsp_valid_next   = 1'b1;
            rsp_run_next     = run_reg;
            rsp_a_next       = mode_a_reg;
            rsp_b_next       = mode_b_reg;
            rsp_period_next  = period_reg;
            rsp_led_next     = led_reg;
            rsp_stepped_next = stepped_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            ticks_to_next_reg <= DUR_W'(1);
            read_index_reg    <= '0;
            audio_start_reg   <= '0;
            active_reg        <= 1'b0;
            playing_audio_reg <= 1'b0;
            playing_click_reg <= 1'b0;
            audio_pending_reg <= 1'b0;
            click_pending_reg <= 1'b0;
            snap_reg          <= '0;
            click_step_reg    <= 1'b0;
            run_reg           <= 1'b0;
            mode_a_reg        <= 1'b1;
            mode_b_reg        <= 1'b1;
            period_reg        <= '0;
            led_reg           <= 1'b0;
            stepped_reg       <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            tick_count_reg    <= tick_count_next;
            ticks_to_next_reg <= ticks_to_next_next;
            read_index_reg    <= read_index_next;
            audio_start_reg   <= audio_start_next;
            active_reg        <= active_next;
            playing_audio_reg <= playing_audio_next;
            playing_click_reg <= playing_click_next;
            audio_pending_reg <= audio_pending_next;
            click_pending_reg <= click_pending_next;
            snap_reg          <= snap_next;
            click_step_reg    <= click_step_next;
            run_reg           <= run_next;
            mode_a_reg        <= mode_a_next;
            mode_b_reg        <= mode_b_next;
            period_reg        <= period_next;
            led_reg           <= led_next;
            stepped_reg       <= stepped_next;
            rsp_valid_reg     <= rsp_valid_next;
            div_cnt_reg       <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        hz_reg          <= hz_next;
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        rsp_run_reg     <= rsp_run_next;
        rsp_a_reg       <= rsp_a_next;
        rsp_b_reg       <= rsp_b_next;
        rsp_period_reg  <= rsp_period_next;
        rsp_led_reg     <= rsp_led_next;
        rsp_stepped_reg <= rsp_stepped_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign pwm_running = rsp_run_reg;
    assign mode_a      = rsp_a_reg;
    assign mode_b      = rsp_b_reg;
    assign pwm_period  = rsp_period_reg;
    assign led_on      = rsp_led_reg;
    assign stepped     = rsp_stepped_reg;

endmodule

// ----- sv/tss_ctrl.sv -----
// ----------------------------------------------------------------------------
// tss_ctrl: sequencer controller
// Takes one request at a time and steps the datapath through tick handling,
// step fetch, period division, step apply and result hand-off.
// ----------------------------------------------------------------------------
module tss_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    op,
    input  tss_pkg::sts_t sts,
    output logic          req_ready,
    output tss_pkg::cmd_t cmd
);

    import tss_pkg::*;

    state_t state_reg;
    state_t state_next;
    op_t    req_op;
    logic   accept;

    assign req_op = op_t'(op);
    assign accept = req_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_op == OP_TICK) ? S_TICK : S_DONE;
                end
            end
            S_TICK:
            begin
                state_next = (sts.tick_due && sts.seq_go) ? S_FETCH : S_DONE;
            end
            S_FETCH: state_next = S_LOAD;
            S_LOAD:  state_next = S_HZ;
            S_HZ:    state_next = S_DIV;
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: state_next = S_DONE;
            S_DONE:
            begin
                if (sts.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        req_ready       = (state_reg == S_IDLE);
        cmd.clr_stepped = accept;
        cmd.wr_table    = accept && (req_op == OP_WRITE);
        cmd.set_audio   = accept && (req_op == OP_PLAY);
        cmd.set_click   = accept && (req_op == OP_CLICK);
        case (state_reg)
            S_TICK:  cmd.tick      = 1'b1;
            S_LOAD:  cmd.load_step = 1'b1;
            S_HZ:    cmd.div_init  = 1'b1;
            S_DIV:   cmd.div_step  = 1'b1;
            S_APPLY: cmd.apply     = 1'b1;
            S_DONE:  cmd.load_out  = sts.slot_free;
            default: cmd.tick      = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/tone_step_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// tone_step_sequencer_unit: step table tone sequencer
// Flow: a table write, play or click request goes straight to the result hand-off; a
// tick executes at most one step, which is fetched, scaled, divided bit by bit and applied.
// Throughput: one request at a time, next taken the cycle after its result loads.
// Reset: asynchronous, clears sequence and output state; table undefined until written.
// ----------------------------------------------------------------------------
module tone_step_sequencer_unit #(
    parameter int TABLE_DEPTH = tss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tss_pkg::PADDR_W-1:0]        paddr,
    input  logic [tss_pkg::PDATA_W-1:0]        pwdata,
    output logic [tss_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [1:0]                         op,
    input  logic [tss_pkg::ADDR_W-1:0]         addr,
    input  logic signed [tss_pkg::FREQ_W-1:0]  freq_mhz,
    input  logic                               volume,
    input  logic signed [tss_pkg::LED_W-1:0]   led_set,
    input  logic [tss_pkg::DUR_W-1:0]          duration,
    input  logic                               click_high,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic                               pwm_running,
    output logic                               mode_a,
    output logic                               mode_b,
    output logic [tss_pkg::PERIOD_W-1:0]       pwm_period,
    output logic                               led_on,
    output logic                               stepped
);

    import tss_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    tss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .op        (op),
        .sts       (sts),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    tss_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .addr        (addr),
        .freq_mhz    (freq_mhz),
        .volume      (volume),
        .led_set     (led_set),
        .duration    (duration),
        .click_high  (click_high),
        .rsp_ready   (rsp_ready),
        .rsp_valid   (rsp_valid),
        .pwm_running (pwm_running),
        .mode_a      (mode_a),
        .mode_b      (mode_b),
        .pwm_period  (pwm_period),
        .led_on      (led_on),
        .stepped     (stepped)
    );

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.slot_free)
        else $error("result register loaded while occupied");

    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_table |-> (req_valid && req_ready))
        else $error("table write without accepted request");

    a_apply_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> $past(cmd.div_step))
        else $error("step applied before division finished");
`endif

endmodule

// ----- bench/tb_tone_step_sequencer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tone_step_sequencer_unit: self-checking bench for the tone step sequencer
// Drives table writes, play, click and tick requests over valid/ready, predicts
// each response with an in-bench model of the sequencer and compares it field by
// field. Runs through several timer clock and click enable settings with random
// idling on both sides and one long response stall.
// ----------------------------------------------------------------------------
module tb_tone_step_sequencer_unit;
    import tss_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_REQS   = 240;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [FREQ_W-1:0] freq;
        logic              vol;
        logic [LED_W-1:0]  led;
        logic [DUR_W-1:0]  dur;
        logic              high;
    } tone_req_t;

    typedef struct packed {
        logic                run;
        logic                a;
        logic                b;
        logic [PERIOD_W-1:0] period;
        logic                led;
        logic                stepped;
    } tone_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic req_valid = 1'b0;
    logic req_ready;
    logic [1:0] op = '0;
    logic [ADDR_W-1:0] addr = '0;
    logic signed [FREQ_W-1:0] freq_mhz = '0;
    logic volume = 1'b0;
    logic signed [LED_W-1:0] led_set = '0;
    logic [DUR_W-1:0] duration = '0;
    logic click_high = 1'b0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    logic pwm_running;
    logic mode_a;
    logic mode_b;
    logic [PERIOD_W-1:0] pwm_period;
    logic led_on;
    logic stepped;

    tone_req_t    pending_reqs[$];
    tone_status_t expected_status[$];

    bit              table_written[256];
    logic [ADDR_W-1:0] table_written_list[$];

    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 64;
    logic        rsp_hold_req = 1'b0;
    logic        rsp_hold_ack = 1'b0;
    int unsigned rsp_hold_left = 0;

    int errors = 0;
    int n_reqs = 0;
    int n_results = 0;
    int n_audio_steps = 0;
    int n_click_steps = 0;

    step_t               seq_table[256];
    logic [CLOCK_W-1:0]  seq_clock_hz = CLOCK_RESET;
    logic                seq_spk_en = 1'b0;
    logic                seq_led_en = 1'b0;
    logic [DUR_W-1:0]    seq_tick_cnt = '0;
    logic [DUR_W-1:0]    seq_wait = 16'd1;
    logic [ADDR_W-1:0]   seq_rd_idx = '0;
    logic [ADDR_W-1:0]   seq_audio_start = '0;
    logic                seq_active = 1'b0;
    logic                seq_audio_on = 1'b0;
    logic                seq_click_on = 1'b0;
    logic                seq_audio_pend = 1'b0;
    logic                seq_click_pend = 1'b0;
    click_snap_t         seq_click_snap = '0;
    logic                seq_click_idx = 1'b0;
    logic                tone_run = 1'b0;
    logic                tone_a = 1'b1;
    logic                tone_b = 1'b1;
    logic [PERIOD_W-1:0] tone_period = '0;
    logic                tone_led = 1'b0;

    tone_step_sequencer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .op          (op),
        .addr        (addr),
        .freq_mhz    (freq_mhz),
        .volume      (volume),
        .led_set     (led_set),
        .duration    (duration),
        .click_high  (click_high),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .pwm_running (pwm_running),
        .mode_a      (mode_a),
        .mode_b      (mode_b),
        .pwm_period  (pwm_period),
        .led_on      (led_on),
        .stepped     (stepped)
    );

    always #6 clk = ~clk;

    function automatic step_t click_step_of(input logic idx);
        step_t s;
        if (!idx)
        begin
            if (seq_click_snap.spk)
                s.freq = seq_click_snap.high ? CLICK_HIGH_MHZ : CLICK_LOW_MHZ;
            else
                s.freq = FREQ_KEEP;
            s.vol = 1'b1;
            s.led = (seq_click_snap.led && seq_click_snap.high) ? LED_ON : LED_KEEP;
            s.dur = CLICK_DUR;
        end
        else
        begin
            s.freq = seq_click_snap.spk ? '0 : FREQ_KEEP;
            s.vol = 1'b0;
            s.led = (seq_click_snap.led && seq_click_snap.high) ? LED_OFF : LED_KEEP;
            s.dur = '0;
        end
        return s;
    endfunction

    function automatic void apply_tone_step(input step_t s);
        logic [FREQ_W-1:0]  hz;
        logic [CLOCK_W-1:0] q;
        if (!s.freq[FREQ_W-1] && s.freq != '0)
        begin
            hz = s.freq / 25'd1000;
            q = (hz == '0) ? 28'd65535 : seq_clock_hz / hz;
            tone_a = 1'b0;
            tone_b = !s.vol;
            tone_period = (q > 28'd65535) ? 16'hFFFF : q[PERIOD_W-1:0];
            tone_run = 1'b1;
        end
        else if (s.freq == '0)
        begin
            tone_run = 1'b0;
            tone_a = 1'b1;
            tone_b = 1'b1;
        end
        if (!s.led[1])
            tone_led = s.led[0];
    endfunction

    function automatic logic advance_sequencer();
        step_t s;
        seq_tick_cnt = seq_tick_cnt + 16'd1;
        if (seq_tick_cnt < seq_wait)
            return 1'b0;
        seq_tick_cnt = '0;
        if (!seq_active)
        begin
            if (seq_audio_pend)
            begin
                seq_active = 1'b1;
                seq_rd_idx = seq_audio_start;
                seq_audio_on = 1'b1;
            end
            else if (seq_click_pend)
            begin
                seq_active = 1'b1;
                seq_click_idx = 1'b0;
                seq_click_on = 1'b1;
            end
        end
        if (!seq_active)
            return 1'b0;
        if (seq_audio_on)
        begin
            s = seq_table[seq_rd_idx];
            seq_rd_idx = seq_rd_idx + 8'd1;
            n_audio_steps++;
        end
        else
        begin
            s = click_step_of(seq_click_idx);
            seq_click_idx = ~seq_click_idx;
            n_click_steps++;
        end
        apply_tone_step(s);
        if (s.dur != '0)
            seq_wait = s.dur;
        else
        begin
            seq_active = 1'b0;
            if (seq_click_on)
            begin
                seq_click_pend = 1'b0;
                seq_click_on = 1'b0;
            end
            else if (seq_audio_on)
            begin
                seq_audio_pend = 1'b0;
                seq_audio_on = 1'b0;
            end
            seq_wait = 16'd1;
        end
        return 1'b1;
    endfunction

    function automatic tone_status_t predict_status(input tone_req_t r);
        tone_status_t st;
        logic         did_step;
        did_step = 1'b0;
        case (r.op)
            OP_TICK:  did_step = advance_sequencer();
            OP_WRITE: seq_table[r.addr] = '{freq: r.freq, vol: r.vol, led: r.led, dur: r.dur};
            OP_PLAY:
            begin
                seq_audio_pend = 1'b1;
                seq_audio_start = r.addr;
            end
            default:
            begin
                if (seq_spk_en || seq_led_en)
                begin
                    seq_click_pend = 1'b1;
                    seq_click_snap = '{high: r.high, led: seq_led_en, spk: seq_spk_en};
                end
                else
                    seq_click_pend = 1'b0;
            end
        endcase
        st.run = tone_run;
        st.a = tone_a;
        st.b = tone_b;
        st.period = tone_period;
        st.led = tone_led;
        st.stepped = did_step;
        return st;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic push_req(input op_t o, input logic [ADDR_W-1:0] a,
                            input logic [FREQ_W-1:0] f, input logic v,
                            input logic [LED_W-1:0] l, input logic [DUR_W-1:0] d,
                            input logic h);
        if (o == OP_WRITE && !table_written[a])
        begin
            table_written[a] = 1'b1;
            table_written_list.push_back(a);
        end
        pending_reqs.push_back('{op: o, addr: a, freq: f, vol: v, led: l, dur: d, high: h});
    endtask

    task automatic queue_random_request();
        int unsigned       pick;
        op_t               o;
        logic [ADDR_W-1:0] a;
        logic [FREQ_W-1:0] f;
        logic [DUR_W-1:0]  d;
        pick = $urandom_range(0, 99);
        a = ADDR_W'($urandom_range(0, 255));
        f = FREQ_W'($urandom);
        d = DUR_W'($urandom);
        if (pick < 50)
            o = OP_TICK;
        else if (pick < 68)
        begin
            o = OP_WRITE;
            if ($urandom_range(0, 1) == 1)
                a = table_written_list[$urandom_range(0, table_written_list.size() - 1)] - 8'd1;
            case ($urandom_range(0, 9))
                0:       f = FREQ_KEEP;
                1:       f = '0;
                2:       f = FREQ_W'($urandom_range(0, 999));
                3:       f = {1'b1, 24'($urandom)};
                4, 5:    f = FREQ_W'($urandom_range(20000, 2000000));
                default: f = FREQ_W'($urandom_range(1000, 16777215));
            endcase
            // keep every written step pointing at a written successor
            if (table_written[a + 8'd1] && $urandom_range(0, 9) != 0)
                d = ($urandom_range(0, 99) < 85) ? DUR_W'($urandom_range(1, 6))
                                                 : DUR_W'($urandom_range(7, 40));
            else
                d = '0;
        end
        else if (pick < 80)
        begin
            o = OP_PLAY;
            a = table_written_list[$urandom_range(0, table_written_list.size() - 1)];
        end
        else
            o = OP_CLICK;
        push_req(o, a, f, 1'($urandom), LED_W'($urandom), d, 1'($urandom));
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [CLOCK_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {{(PDATA_W - CLOCK_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CLOCK: seq_clock_hz = val;
            REG_SPK:   seq_spk_en = val[0];
            REG_LED:   seq_led_en = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_for_idle();
        while (pending_reqs.size() != 0 || expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : drive_proc
        tone_req_t    cur;
        tone_status_t st;
        bit           offer;
        if (req_valid && req_ready)
        begin
            cur = pending_reqs.pop_front();
            st = predict_status(cur);
            expected_status.push_back(st);
            n_reqs++;
        end
        if (!(req_valid && !req_ready))
        begin
            offer = (pending_reqs.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
            req_valid <= offer;
            if (offer)
            begin
                cur = pending_reqs[0];
                op <= cur.op;
                addr <= cur.addr;
                freq_mhz <= cur.freq;
                volume <= cur.vol;
                led_set <= cur.led;
                duration <= cur.dur;
                click_high <= cur.high;
            end
        end
    end

    always @(posedge clk)
    begin : hold_proc
        if (rsp_hold_left != 0)
            rsp_hold_left <= rsp_hold_left - 1;
        else if (rsp_hold_req != rsp_hold_ack)
        begin
            rsp_hold_left <= HOLD_CYCLES;
            rsp_hold_ack <= rsp_hold_req;
        end
    end

    always @(posedge clk)
    begin : check_proc
        tone_status_t want;
        if (rsp_valid && rsp_ready)
        begin
            n_results++;
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t: response with no request outstanding", $time);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("pwm_running", want.run, pwm_running);
                check_field("mode_a", want.a, mode_a);
                check_field("mode_b", want.b, mode_b);
                check_field("pwm_period", want.period, pwm_period);
                check_field("led_on", want.led, led_on);
                check_field("stepped", want.stepped, stepped);
            end
        end
        rsp_ready <= (rsp_hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        #20000000;
        $display("tb_tone_step_sequencer_unit: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int                 ph;
        int                 i;
        logic [CLOCK_W-1:0] clk_val;
        logic               spk_val;
        logic               led_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_req(OP_TICK, 8'd0, '0, 1'b0, LED_OFF, '0, 1'b0);
        push_req(OP_WRITE, 8'd0, 25'd16777215, 1'b1, LED_ON, 16'd0, 1'b0);
        push_req(OP_WRITE, 8'd255, 25'd1000, 1'b0, LED_KEEP, 16'd2, 1'b0);
        push_req(OP_WRITE, 8'd254, 25'd999, 1'b1, 2'b10, 16'd1, 1'b0);
        push_req(OP_WRITE, 8'd253, FREQ_KEEP, 1'b0, LED_OFF, 16'd3, 1'b0);
        push_req(OP_WRITE, 8'd252, 25'h1000000, 1'b1, LED_ON, 16'd1, 1'b0);
        push_req(OP_WRITE, 8'd251, '0, 1'b0, LED_ON, 16'd1, 1'b0);
        push_req(OP_WRITE, 8'd11, 25'd440000, 1'b1, LED_OFF, 16'd0, 1'b0);
        push_req(OP_WRITE, 8'd10, 25'd123456, 1'b0, LED_ON, 16'hFFFF, 1'b0);
        push_req(OP_CLICK, 8'd0, '0, 1'b0, LED_OFF, '0, 1'b1);
        push_req(OP_PLAY, 8'd251, '0, 1'b0, LED_OFF, '0, 1'b0);
        for (i = 0; i < 9; i++)
            push_req(OP_TICK, 8'd0, '0, 1'b0, LED_OFF, '0, 1'b0);
        push_req(OP_CLICK, 8'd0, '0, 1'b0, LED_OFF, '0, 1'b0);
        // shorten the long step before it can be played
        push_req(OP_WRITE, 8'd10, 25'd2000000, 1'b1, LED_OFF, 16'd1, 1'b0);
        push_req(OP_PLAY, 8'd10, '0, 1'b0, LED_OFF, '0, 1'b0);
        push_req(OP_TICK, 8'd0, '0, 1'b0, LED_OFF, '0, 1'b0);
        push_req(OP_TICK, 8'd0, '0, 1'b0, LED_OFF, '0, 1'b0);

        for (ph = 0; ph < 5; ph++)
        begin
            wait_for_idle();
            case (ph)
                0:
                begin
                    clk_val = 28'd160000000;
                    spk_val = 1'b1;
                    led_val = 1'b1;
                end
                1:
                begin
                    clk_val = 28'd1;
                    spk_val = 1'b1;
                    led_val = 1'b0;
                end
                2:
                begin
                    clk_val = CLOCK_W'($urandom_range(1, 160000000));
                    spk_val = 1'b0;
                    led_val = 1'b1;
                end
                3:
                begin
                    clk_val = '0;
                    spk_val = 1'b0;
                    led_val = 1'b0;
                end
                default:
                begin
                    clk_val = {CLOCK_W{1'b1}};
                    spk_val = 1'b1;
                    led_val = 1'b1;
                end
            endcase
            apb_write(REG_CLOCK, clk_val);
            apb_write(REG_SPK, CLOCK_W'(spk_val));
            apb_write(REG_LED, CLOCK_W'(led_val));
            send_idle_pct = (ph == 0) ? 18 : (ph < 3) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph < 3) ? 18 : 0;
            @(negedge clk);
            for (i = 0; i < PHASE_REQS / 2; i++)
                queue_random_request();
            // stall responses while requests keep coming
            if (ph == 3)
                rsp_hold_req = ~rsp_hold_req;
            for (i = 0; i < PHASE_REQS / 2; i++)
                queue_random_request();
        end
        wait_for_idle();

        if (expected_status.size() != 0)
        begin
            errors++;
            $display("%0t: %0d responses never arrived", $time, expected_status.size());
        end
        $display("Covered %0d requests and %0d responses over 5 clock/click settings,",
                 n_reqs, n_results);
        $display("with %0d audio steps and %0d click steps executed; %0d errors.",
                 n_audio_steps, n_click_steps, errors);
        if (errors == 0)
            $display("tb_tone_step_sequencer_unit: PASS");
        else
            $display("tb_tone_step_sequencer_unit: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tss_pkg.sv
sv/tss_ram.sv
sv/tss_cfg.sv
sv/tss_dp.sv
sv/tss_ctrl.sv
sv/tone_step_sequencer_unit.sv
bench/tb_tone_step_sequencer_unit.sv
